// File: hdl/mah_pkg.sv
// ----------------------------------------------------------------------------
// Handover controller package
// Types and constants shared by the manual/automatic handover controller.
// ----------------------------------------------------------------------------
package mah_pkg;

    // Controller modes, one-hot encoded.
    typedef enum logic [7:0] {
        ST_MANUAL       = 8'b0000_0001,
        ST_START_AUTO   = 8'b0000_0010,
        ST_ACK_AUTO     = 8'b0000_0100,
        ST_OVERTIME     = 8'b0000_1000,
        ST_AUTO         = 8'b0001_0000,
        ST_START_MANUAL = 8'b0010_0000,
        ST_ACK_MANUAL   = 8'b0100_0000,
        ST_BRAKE        = 8'b1000_0000
    } t_mode;

    // Mode codes as reported on the result channel.
    localparam logic [2:0] MODE_MANUAL       = 3'd0;
    localparam logic [2:0] MODE_START_AUTO   = 3'd1;
    localparam logic [2:0] MODE_ACK_AUTO     = 3'd2;
    localparam logic [2:0] MODE_OVERTIME     = 3'd3;
    localparam logic [2:0] MODE_AUTO         = 3'd4;
    localparam logic [2:0] MODE_START_MANUAL = 3'd5;
    localparam logic [2:0] MODE_ACK_MANUAL   = 3'd6;
    localparam logic [2:0] MODE_BRAKE        = 3'd7;

    // Display event codes.
    localparam logic [3:0] EV_NONE             = 4'd0;
    localparam logic [3:0] EV_AUTO_COUNTDOWN   = 4'd1;
    localparam logic [3:0] EV_AUTO_TIMEOUT     = 4'd2;
    localparam logic [3:0] EV_GEAR_CONFIRM     = 4'd3;
    localparam logic [3:0] EV_AUTO_DONE        = 4'd4;
    localparam logic [3:0] EV_MANUAL_DONE      = 4'd5;
    localparam logic [3:0] EV_MANUAL_COUNTDOWN = 4'd6;
    localparam logic [3:0] EV_MANUAL_TIMEOUT   = 4'd7;
    localparam logic [3:0] EV_TWO_GEAR_CONFIRM = 4'd8;

    // Configuration register indexes.
    localparam logic CFG_TIMEOUT_SECONDS = 1'b0;
    localparam logic CFG_HANDOVER_GEAR   = 1'b1;

    // Reset values of the configuration registers.
    localparam logic [15:0]       TIMEOUT_RESET = 16'd10;
    localparam logic signed [4:0] HANDOVER_RESET = 5'sd8;

    // Largest gear step that still allows a two-gear confirmation.
    localparam logic signed [5:0] GEAR_STEP_MAX = 6'sd2;

    typedef struct packed {
        logic [15:0]       timeout_seconds;
        logic signed [4:0] handover_gear;
    } t_cfg;

    typedef struct packed {
        logic              second_tick;
        logic              emergency;
        logic              manual_ack;
        logic              manual_request;
        logic              auto_ack;
        logic signed [4:0] auto_request_gear;
        logic              auto_request;
        logic signed [4:0] suggested_gear;
        logic signed [4:0] throttle;
    } t_item;

    typedef struct packed {
        logic [2:0]        mode_now;
        logic              clear_requests;
        logic [3:0]        event_code;
        logic              manual_mode_set;
        logic signed [4:0] gear_out;
    } t_result;

    // Map a one-hot mode to its reported code.
    function automatic logic [2:0] mode_code(input t_mode m);
        logic [2:0] c;
        unique case (m)
            ST_MANUAL:       c = MODE_MANUAL;
            ST_START_AUTO:   c = MODE_START_AUTO;
            ST_ACK_AUTO:     c = MODE_ACK_AUTO;
            ST_OVERTIME:     c = MODE_OVERTIME;
            ST_AUTO:         c = MODE_AUTO;
            ST_START_MANUAL: c = MODE_START_MANUAL;
            ST_ACK_MANUAL:   c = MODE_ACK_MANUAL;
            default:         c = MODE_BRAKE;
        endcase
        return c;
    endfunction

endpackage

// File: hdl/mah_step.sv
// ----------------------------------------------------------------------------
// Handover step logic
// Combinational next-state and result logic for one control step.
// ----------------------------------------------------------------------------
module mah_step
    import mah_pkg::*;
#(
    parameter int TIMER_BITS = 16
) (
    input  t_mode                 i_mode,
    input  logic                  i_timer_running,
    input  logic [TIMER_BITS-1:0] i_elapsed,
    input  t_cfg                  i_cfg,
    input  t_item                 i_item,
    output t_mode                 o_mode,
    output logic                  o_timer_running,
    output logic [TIMER_BITS-1:0] o_elapsed,
    output t_result               o_result
);

    localparam int CMP_BITS = (TIMER_BITS > 16) ? TIMER_BITS : 16;

    logic [TIMER_BITS-1:0] elapsed_ticked;
    logic [CMP_BITS-1:0]   elapsed_ext;
    logic [CMP_BITS-1:0]   timeout_ext;
    logic                  over;
    logic signed [4:0]     thr;
    logic signed [4:0]     gear_min;
    logic signed [5:0]     gear_diff;
    logic                  check_emer;
    t_mode                 mode_step;

    // Seconds counter advances first, saturating at all ones.
    always_comb begin
        if (i_timer_running && i_item.second_tick && !(&i_elapsed)) begin
            elapsed_ticked = i_elapsed + {{(TIMER_BITS-1){1'b0}}, 1'b1};
        end else begin
            elapsed_ticked = i_elapsed;
        end
    end

    assign elapsed_ext = CMP_BITS'(elapsed_ticked);
    assign timeout_ext = CMP_BITS'(i_cfg.timeout_seconds);
    assign over        = elapsed_ext > timeout_ext;

    assign thr       = i_item.throttle;
    assign gear_min  = (i_item.suggested_gear > 5'sd0) ? 5'sd0 : i_item.suggested_gear;
    assign gear_diff = {thr[4], thr} - {i_item.suggested_gear[4], i_item.suggested_gear};

    // Mode transitions and per-step outputs.
    always_comb begin
        mode_step                = i_mode;
        o_timer_running          = i_timer_running;
        o_elapsed                = elapsed_ticked;
        o_result.gear_out        = i_item.suggested_gear;
        o_result.manual_mode_set = 1'b0;
        o_result.event_code      = EV_NONE;
        o_result.clear_requests  = 1'b0;
        check_emer               = 1'b1;
        unique case (i_mode)
            ST_MANUAL: begin
                o_timer_running          = 1'b0;
                o_elapsed                = '0;
                if (i_item.auto_request) begin
                    mode_step = ST_START_AUTO;
                end
                o_result.gear_out        = thr;
                o_result.manual_mode_set = 1'b1;
                check_emer               = 1'b0;
            end
            ST_START_AUTO: begin
                if (!i_timer_running) begin
                    o_timer_running     = 1'b1;
                    o_elapsed           = '0;
                    o_result.event_code = EV_AUTO_COUNTDOWN;
                end else if (over) begin
                    mode_step           = ST_OVERTIME;
                    o_result.event_code = EV_AUTO_TIMEOUT;
                end else if (i_item.auto_request_gear == i_cfg.handover_gear) begin
                    mode_step           = ST_ACK_AUTO;
                    o_result.event_code = EV_GEAR_CONFIRM;
                end else if (thr == i_cfg.handover_gear) begin
                    mode_step               = ST_AUTO;
                    o_result.clear_requests = 1'b1;
                    o_result.event_code     = EV_AUTO_DONE;
                end
            end
            ST_ACK_AUTO: begin
                if (over) begin
                    mode_step           = ST_OVERTIME;
                    o_result.event_code = EV_AUTO_TIMEOUT;
                end else if (i_item.auto_ack) begin
                    mode_step               = ST_AUTO;
                    o_result.clear_requests = 1'b1;
                    o_result.event_code     = EV_AUTO_DONE;
                end
            end
            ST_OVERTIME: begin
                o_result.gear_out = gear_min;
                if (thr <= gear_min) begin
                    mode_step               = ST_MANUAL;
                    o_result.clear_requests = 1'b1;
                    o_result.event_code     = EV_MANUAL_DONE;
                end
            end
            ST_AUTO: begin
                o_timer_running = 1'b0;
                o_elapsed       = '0;
                if ((thr != i_cfg.handover_gear) || i_item.manual_request) begin
                    mode_step = ST_START_MANUAL;
                end
            end
            ST_START_MANUAL: begin
                if (!i_timer_running) begin
                    o_timer_running     = 1'b1;
                    o_elapsed           = '0;
                    o_result.event_code = EV_MANUAL_COUNTDOWN;
                end else if (over) begin
                    mode_step           = ST_OVERTIME;
                    o_result.event_code = EV_MANUAL_TIMEOUT;
                end else if (thr <= i_item.suggested_gear) begin
                    mode_step               = ST_MANUAL;
                    o_result.clear_requests = 1'b1;
                    o_result.event_code     = EV_MANUAL_DONE;
                end else if (gear_diff <= GEAR_STEP_MAX) begin
                    mode_step           = ST_ACK_MANUAL;
                    o_result.event_code = EV_TWO_GEAR_CONFIRM;
                end
            end
            ST_ACK_MANUAL: begin
                if (over) begin
                    mode_step           = ST_OVERTIME;
                    o_result.event_code = EV_MANUAL_TIMEOUT;
                end else if (i_item.manual_ack) begin
                    mode_step               = ST_MANUAL;
                    o_result.clear_requests = 1'b1;
                    o_result.event_code     = EV_MANUAL_DONE;
                end
            end
            default: begin
                o_result.gear_out = 5'sd0;
                if (thr < 5'sd0) begin
                    mode_step               = ST_MANUAL;
                    o_result.clear_requests = 1'b1;
                    o_result.event_code     = EV_MANUAL_DONE;
                end
                check_emer = 1'b0;
            end
        endcase
        // Emergency overrides the transition, except in manual and brake modes, but keeps the step's event.
        o_mode            = (check_emer && i_item.emergency) ? ST_BRAKE : mode_step;
        o_result.mode_now = mode_code(o_mode);
    end

endmodule

// File: hdl/manual_auto_handover_fsm_core.sv
// Each input transaction passes through the input register, then the result register.
// Throughput: one control step per cycle while the output is not stalled; the mode,
// timer flag and seconds counter update in the same cycle the step enters the result register.
// Reset (synchronous, active low) returns to manual mode with the timer stopped,
// clears both stages and restores the configuration defaults.
// ----------------------------------------------------------------------------
// Manual/automatic handover controller
// Input register, single-pass step logic and result register with stall.
// ----------------------------------------------------------------------------
module manual_auto_handover_fsm_core
    import mah_pkg::*;
#(
    parameter int TIMER_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Configuration write channel
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_index,
    input  logic [15:0] i_cfg_data,
    // Control step input
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // tdata from bit 0: throttle[4:0], suggested_gear[9:5], auto_request[10],
    // auto_request_gear[15:11], auto_ack[16], manual_request[17],
    // manual_ack[18], emergency[19], second_tick[20], zero[23:21]
    input  logic [23:0] s_axis_tdata,
    // Step result output
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // tdata from bit 0: gear_out[4:0], manual_mode_set[5], event_code[9:6],
    // clear_requests[10], mode_now[13:11], zero[15:14]
    output logic [15:0] m_axis_tdata
);

    t_cfg                  r_cfg;
    t_item                 r_item;
    logic                  r_item_valid;
    t_result               r_result;
    logic                  r_result_valid;
    t_mode                 r_mode;
    logic                  r_timer_running;
    logic [TIMER_BITS-1:0] r_elapsed;

    t_mode                 n_mode;
    logic                  n_timer_running;
    logic [TIMER_BITS-1:0] n_elapsed;
    t_result               n_result;
    logic                  process;

    // Configuration registers; writes are always taken.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.timeout_seconds <= TIMEOUT_RESET;
            r_cfg.handover_gear   <= HANDOVER_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_TIMEOUT_SECONDS: r_cfg.timeout_seconds <= i_cfg_data;
                default:             r_cfg.handover_gear   <= i_cfg_data[4:0];
            endcase
        end
    end

    // A step moves on when the result register is free or being emptied.
    assign process       = r_item_valid && (!r_result_valid || m_axis_tready);
    assign s_axis_tready = !r_item_valid || process;

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_item_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_item_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_item <= t_item'(s_axis_tdata[20:0]);
        end
    end

    mah_step #(
        .TIMER_BITS(TIMER_BITS)
    ) u_step (
        .i_mode          (r_mode),
        .i_timer_running (r_timer_running),
        .i_elapsed       (r_elapsed),
        .i_cfg           (r_cfg),
        .i_item          (r_item),
        .o_mode          (n_mode),
        .o_timer_running (n_timer_running),
        .o_elapsed       (n_elapsed),
        .o_result        (n_result)
    );

    // Controller state advances once per processed step.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode          <= ST_MANUAL;
            r_timer_running <= 1'b0;
            r_elapsed       <= '0;
        end else if (process) begin
            r_mode          <= n_mode;
            r_timer_running <= n_timer_running;
            r_elapsed       <= n_elapsed;
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_result_valid <= 1'b0;
        end else if (process) begin
            r_result_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_result_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (process) begin
            r_result <= n_result;
        end
    end

    assign m_axis_tvalid = r_result_valid;
    assign m_axis_tdata  = {2'b00, r_result};

endmodule
